// ===== rtl/gas_pkg.sv =====
package gas_pkg;

  // serial divider
  localparam int DIVD_W = 27;
  localparam int DIVS_W = 16;
  localparam int DCNT_W = $clog2(DIVD_W);

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  // action kinds
  localparam logic [2:0] AK_NONE    = 3'd0;
  localparam logic [2:0] AK_SERVO   = 3'd1;
  localparam logic [2:0] AK_LIFT_TO = 3'd2;
  localparam logic [2:0] AK_LIFT_UP = 3'd3;
  localparam logic [2:0] AK_LIFT_DN = 3'd4;
  localparam logic [2:0] AK_RANGE   = 3'd5;
  localparam logic [2:0] AK_FORWARD = 3'd6;
  localparam logic [2:0] AK_DONE    = 3'd7;

  // servo channels
  localparam logic [2:0] CH_NONE   = 3'd0;
  localparam logic [2:0] CH_CLAW   = 3'd5;
  localparam logic [2:0] CH_EXT    = 3'd6;
  localparam logic [2:0] CH_GIMBAL = 3'd7;

  // sequence phases
  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_GRAB_DIST   = 4'd1;
  localparam logic [3:0] PH_GRAB_OPEN   = 4'd2;
  localparam logic [3:0] PH_GRAB_CLOSE  = 4'd3;
  localparam logic [3:0] PH_GRAB_GRIP   = 4'd4;
  localparam logic [3:0] PH_PUT_LIFT    = 4'd5;
  localparam logic [3:0] PH_PUT_EXTEND  = 4'd6;
  localparam logic [3:0] PH_PUT_ROTATE  = 4'd7;
  localparam logic [3:0] PH_PUT_OPEN    = 4'd8;
  localparam logic [3:0] PH_SKIP_LIFT   = 4'd9;
  localparam logic [3:0] PH_SKIP_EXTEND = 4'd10;
  localparam logic [3:0] PH_SKIP_ROTATE = 4'd11;
  localparam logic [3:0] PH_BAD_DIST    = 4'd12;
  localparam logic [3:0] PH_BAD_CLOSE   = 4'd13;
  localparam logic [3:0] PH_BAD_OPEN    = 4'd14;

  // item functions
  localparam logic [1:0] FN_TICK   = 2'd0;
  localparam logic [1:0] FN_VISION = 2'd1;
  localparam logic [1:0] FN_CANCEL = 2'd2;
  localparam logic [1:0] FN_MOVE   = 2'd3;

  // vision commands
  localparam logic [2:0] CMD_GRAB    = 3'd0;
  localparam logic [2:0] CMD_GIM_DN  = 3'd1;
  localparam logic [2:0] CMD_GIM_UP  = 3'd2;
  localparam logic [2:0] CMD_LIFT_UP = 3'd3;
  localparam logic [2:0] CMD_LIFT_DN = 3'd4;
  localparam logic [2:0] CMD_SKIP    = 3'd5;
  localparam logic [2:0] CMD_BAD     = 3'd6;

  // config register indexes
  localparam logic [2:0] CFG_RANGE   = 3'd0;
  localparam logic [2:0] CFG_OPEN    = 3'd1;
  localparam logic [2:0] CFG_EXTEND  = 3'd2;
  localparam logic [2:0] CFG_CLOSE   = 3'd3;
  localparam logic [2:0] CFG_LIFT    = 3'd4;
  localparam logic [2:0] CFG_RETRACT = 3'd5;
  localparam logic [2:0] CFG_GIMBAL  = 3'd6;
  localparam logic [2:0] CFG_RELEASE = 3'd7;

  localparam logic [15:0] CFG_RESET [8] = '{16'd200, 16'd400, 16'd1200, 16'd500,
                                            16'd1800, 16'd600, 16'd200, 16'd600};

  localparam logic [31:0] BAD_WAIT_MS  = 32'd500;
  localparam logic [15:0] MIN_MOVE_MS  = 16'd300;
  localparam logic [15:0] STEP_MOVE_MS = 16'd300;
  // |diff| * 13 / 10 as one multiply and a 19-bit shift: 13 * ceil(2^19 / 10),
  // exact for |diff| below 5000
  localparam logic [19:0] MOVE_RECIP   = 20'd681577;

endpackage

// ===== rtl/gas_div.sv =====
module gas_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gas_pkg::div_req_t                req,
  output logic                             done,
  output logic [gas_pkg::DIVD_W-1:0]       quotient
);

  logic                              busy_r;
  logic                              done_r;
  logic [gas_pkg::DCNT_W-1:0]        cnt_r;
  logic [gas_pkg::DIVS_W-1:0]        rem_r;
  logic [gas_pkg::DIVD_W-1:0]        quo_r;
  logic [gas_pkg::DIVS_W-1:0]        dsr_r;
  logic [gas_pkg::DIVS_W:0]          rem_sh;
  logic [gas_pkg::DIVS_W:0]          diff;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_r, quo_r[gas_pkg::DIVD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        if (rem_sh >= {1'b0, dsr_r}) begin
          rem_r <= diff[gas_pkg::DIVS_W-1:0];
          quo_r <= {quo_r[gas_pkg::DIVD_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[gas_pkg::DIVS_W-1:0];
          quo_r <= {quo_r[gas_pkg::DIVD_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == gas_pkg::DCNT_W'(gas_pkg::DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/grab_action_sequencer_top.sv =====
// channel  | direction | ports
// input    | in        | in_valid, in_stall, in_func .. in_move_duration
// result   | out       | out_valid, out_stall, out_action_kind .. out_busy_res
// config   | in        | cfg_we, cfg_index, cfg_wdata
//
// After acceptance a tick passes S_DISP, S_GLIFT, S_GMOVE and S_TICK before its results,
// a vision item S_DISP and S_VISION, a cancel or move request S_DISP; a queued command
// run by a tick also passes S_VISION. Results are then presented one at a time in S_OUT,
// each taken while out_stall is low (an item with no result still passes S_OUT). A tick
// that interpolates the gimbal also waits in S_GDIV for the serial divider.
// in_stall is high from acceptance until the last result has been taken.
// rst_n is synchronous; config registers return to their defaults.
module grab_action_sequencer_top #(
  parameter logic [7:0] RETRY_LIMIT = 8'd5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [2:0]         in_vision_command,
  input  logic [31:0]        in_now_ms,
  input  logic [11:0]        in_range_mm,
  input  logic signed [10:0] in_gimbal_angle,
  input  logic signed [10:0] in_extend_angle,
  input  logic [8:0]         in_lift_height,
  input  logic               in_tree_target,
  input  logic signed [10:0] in_move_target,
  input  logic [15:0]        in_move_duration,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_action_kind,
  output logic [2:0]         out_servo_channel,
  output logic signed [10:0] out_action_value,
  output logic               out_last_action,
  output logic               out_busy_res,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_VISION, S_GLIFT, S_GMOVE, S_GDIV, S_TICK, S_OUT
  } state_t;

  function automatic logic signed [10:0] sat9(input logic signed [12:0] v);
    if (v > 13'sd900) return 11'sd900;
    else if (v < -13'sd900) return -11'sd900;
    else return v[10:0];
  endfunction

  function automatic logic reached(input logic [31:0] n, input logic [31:0] t);
    logic [31:0] df;
    df = n - t;
    return ~df[31];
  endfunction

  state_t state_r, state_nxt;

  logic [15:0] cfg_r [8];

  // latched item
  logic [1:0]         func_r;
  logic [2:0]         cmd_r, cmd_nxt;
  logic [31:0]        now_r;
  logic [11:0]        range_r;
  logic signed [10:0] gim_r, ext_r, mtgt_r;
  logic [8:0]         lift_r;
  logic               tree_r;
  logic [15:0]        mdur_r;

  // architectural state
  logic [3:0]         phase_r, phase_nxt;
  logic [31:0]        deadline_r, deadline_nxt;
  logic               settle_r, settle_nxt;
  logic [7:0]         retry_r, retry_nxt;
  logic               moving_r, moving_nxt;
  logic               lpend_r, lpend_nxt;
  logic signed [10:0] mstart_r, mstart_nxt;
  logic signed [10:0] mend_r, mend_nxt;
  logic [31:0]        mtime_r, mtime_nxt;
  logic [15:0]        mlen_r, mlen_nxt;
  logic [31:0]        ldead_r, ldead_nxt;
  logic               qvalid_r, qvalid_nxt;
  logic [2:0]         qcmd_r, qcmd_nxt;

  // result buffer
  logic [2:0]         rkind_r [4];
  logic [2:0]         rch_r [4];
  logic signed [10:0] rval_r [4];
  logic [2:0]         rcnt_r, rcnt_nxt;
  logic [1:0]         oidx_r, oidx_nxt;

  // emissions of this cycle
  logic [2:0]         ek [2];
  logic [2:0]         ec [2];
  logic signed [10:0] ev [2];
  logic [1:0]         en;

  gas_pkg::div_req_t    dreq;
  logic                 ddone;
  logic [gas_pkg::DIVD_W-1:0] dquo;

  gas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .done     (ddone),
    .quotient (dquo)
  );

  logic               busy;
  logic               in_acc, out_acc;

  // extension target
  logic signed [10:0] ext_base;
  logic [12:0]        rng50;
  logic [15:0]        rng7;
  logic signed [16:0] ext_t, ext_h;
  logic signed [10:0] ext_tgt;

  // interpolation
  logic signed [11:0] d12;
  logic [10:0]        ad11;
  logic [31:0]        elapsed;
  logic signed [11:0] interp;

  // centering move time
  logic signed [11:0] ctr_tgt, ctr_diff;
  logic [10:0]        ctr_mag;
  logic [30:0]        ctr_prod;
  logic [15:0]        ctr_dur;

  // start of a gimbal move
  logic               sg_go, sg_lift;
  logic signed [11:0] sg_target;
  logic [15:0]        sg_dur;
  logic signed [10:0] sg_end;

  assign busy    = (phase_r != gas_pkg::PH_IDLE) || moving_r || lpend_r;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT) && (rcnt_r != 3'd0);
  assign out_acc   = out_valid && !out_stall;

  assign ext_base = (ext_r < -11'sd800) ? -11'sd800 : ext_r;
  assign rng50    = {1'b0, range_r} + 13'd50;
  assign rng7     = 16'({3'b0, rng50} * 16'd7);
  assign ext_t    = $signed({{5{ext_base[10]}}, ext_base, 1'b0}) + $signed({1'b0, rng7});
  assign ext_h    = (ext_t + 17'sd1) >>> 1;
  assign ext_tgt  = (ext_h > 17'sd250) ? 11'sd250 :
                    ((ext_h < -17'sd800) ? -11'sd800 : ext_h[10:0]);

  assign d12     = {mend_r[10], mend_r} - {mstart_r[10], mstart_r};
  assign ad11    = d12[11] ? 11'(-d12) : d12[10:0];
  assign elapsed = now_r - mtime_r;
  assign interp  = d12[11] ? ({mstart_r[10], mstart_r} - $signed({1'b0, dquo[10:0]}))
                           : ({mstart_r[10], mstart_r} + $signed({1'b0, dquo[10:0]}));

  assign ctr_tgt  = (phase_r == gas_pkg::PH_SKIP_LIFT && gim_r > 11'sd750) ? -12'sd900 : 12'sd0;
  assign ctr_diff = ctr_tgt - {gim_r[10], gim_r};
  assign ctr_mag  = ctr_diff[11] ? 11'(-ctr_diff) : ctr_diff[10:0];
  assign ctr_prod = {20'd0, ctr_mag} * {11'd0, gas_pkg::MOVE_RECIP};
  assign ctr_dur  = ({4'd0, ctr_prod[30:19]} < gas_pkg::MIN_MOVE_MS) ? gas_pkg::MIN_MOVE_MS
                                                                     : {4'd0, ctr_prod[30:19]};

  assign sg_end = sat9({sg_target[11], sg_target});

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    phase_nxt   = phase_r;
    deadline_nxt = deadline_r;
    settle_nxt  = settle_r;
    retry_nxt   = retry_r;
    moving_nxt  = moving_r;
    lpend_nxt   = lpend_r;
    mstart_nxt  = mstart_r;
    mend_nxt    = mend_r;
    mtime_nxt   = mtime_r;
    mlen_nxt    = mlen_r;
    ldead_nxt   = ldead_r;
    qvalid_nxt  = qvalid_r;
    qcmd_nxt    = qcmd_r;
    rcnt_nxt    = rcnt_r;
    oidx_nxt    = oidx_r;
    for (int i = 0; i < 2; i++) begin
      ek[i] = gas_pkg::AK_NONE;
      ec[i] = gas_pkg::CH_NONE;
      ev[i] = '0;
    end
    en        = 2'd0;
    dreq      = '0;
    sg_go     = 1'b0;
    sg_lift   = 1'b0;
    sg_target = '0;
    sg_dur    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DISP;
          rcnt_nxt  = 3'd0;
          oidx_nxt  = 2'd0;
          cmd_nxt   = in_vision_command;
        end
      end

      S_DISP: begin
        case (func_r)
          gas_pkg::FN_TICK:   state_nxt = S_GLIFT;
          gas_pkg::FN_VISION: state_nxt = S_VISION;
          gas_pkg::FN_CANCEL: begin
            phase_nxt  = gas_pkg::PH_IDLE;
            moving_nxt = 1'b0;
            lpend_nxt  = 1'b0;
            qvalid_nxt = 1'b0;
            state_nxt  = S_OUT;
          end
          default: begin
            sg_go     = 1'b1;
            sg_lift   = 1'b1;
            sg_target = {mtgt_r[10], mtgt_r};
            sg_dur    = mdur_r;
            state_nxt = S_OUT;
          end
        endcase
      end

      S_GLIFT: begin
        if (lpend_r && reached(now_r, ldead_r)) begin
          lpend_nxt  = 1'b0;
          mstart_nxt = gim_r;
          mtime_nxt  = now_r;
          moving_nxt = 1'b1;
        end
        state_nxt = S_GMOVE;
      end

      S_GMOVE: begin
        state_nxt = S_TICK;
        if (moving_r) begin
          if (elapsed >= {16'd0, mlen_r}) begin
            ek[0] = gas_pkg::AK_SERVO; ec[0] = gas_pkg::CH_GIMBAL;
            ev[0] = sat9({{2{mend_r[10]}}, mend_r});
            en = 2'd1;
            moving_nxt = 1'b0;
          end else begin
            dreq.start    = 1'b1;
            dreq.dividend = {16'd0, ad11} * {11'd0, elapsed[15:0]};
            dreq.divisor  = mlen_r;
            state_nxt     = S_GDIV;
          end
        end
      end

      S_GDIV: begin
        if (ddone) begin
          ek[0] = gas_pkg::AK_SERVO; ec[0] = gas_pkg::CH_GIMBAL;
          ev[0] = sat9({interp[11], interp});
          en = 2'd1;
          state_nxt = S_TICK;
        end
      end

      S_TICK: begin
        state_nxt = S_OUT;
        if (qvalid_r && !busy) begin
          qvalid_nxt = 1'b0;
          cmd_nxt    = qcmd_r;
          state_nxt  = S_VISION;
        end else if (reached(now_r, deadline_r)) begin
          case (phase_r)
            gas_pkg::PH_GRAB_DIST: begin
              ek[0] = gas_pkg::AK_SERVO; ec[0] = gas_pkg::CH_CLAW; ev[0] = -11'sd300;
              en = 2'd1;
              phase_nxt = gas_pkg::PH_GRAB_OPEN;
              deadline_nxt = now_r + {16'd0, cfg_r[gas_pkg::CFG_OPEN]};
            end
            gas_pkg::PH_GRAB_OPEN: begin
              ek[0] = gas_pkg::AK_SERVO; ec[0] = gas_pkg::CH_EXT; ev[0] = ext_tgt;
              en = 2'd1;
              phase_nxt = gas_pkg::PH_GRAB_CLOSE;
              deadline_nxt = now_r + {16'd0, cfg_r[gas_pkg::CFG_EXTEND]};
            end
            gas_pkg::PH_GRAB_CLOSE: begin
              ek[0] = gas_pkg::AK_SERVO; ec[0] = gas_pkg::CH_CLAW; ev[0] = 11'sd30;
              en = 2'd1;
              phase_nxt = gas_pkg::PH_GRAB_GRIP;
              deadline_nxt = now_r + {16'd0, cfg_r[gas_pkg::CFG_CLOSE]};
            end
            gas_pkg::PH_GRAB_GRIP, gas_pkg::PH_BAD_OPEN: begin
              ek[0] = gas_pkg::AK_SERVO; ec[0] = gas_pkg::CH_EXT; ev[0] = -11'sd800;
              en = 2'd1;
              phase_nxt = gas_pkg::PH_PUT_EXTEND;
              deadline_nxt = now_r + {16'd0, cfg_r[gas_pkg::CFG_RETRACT]};
            end
            gas_pkg::PH_PUT_EXTEND, gas_pkg::PH_SKIP_EXTEND: begin
              ek[0] = gas_pkg::AK_LIFT_TO; ev[0] = 11'sd250;
              en = 2'd1;
              phase_nxt = (phase_r == gas_pkg::PH_PUT_EXTEND) ? gas_pkg::PH_PUT_LIFT
                                                              : gas_pkg::PH_SKIP_LIFT;
              deadline_nxt = now_r + {16'd0, cfg_r[gas_pkg::CFG_LIFT]};
            end
            gas_pkg::PH_PUT_LIFT, gas_pkg::PH_SKIP_LIFT: begin
              sg_go     = 1'b1;
              sg_target = ctr_tgt;
              sg_dur    = ctr_dur;
              phase_nxt = (phase_r == gas_pkg::PH_PUT_LIFT) ? gas_pkg::PH_PUT_ROTATE
                                                            : gas_pkg::PH_SKIP_ROTATE;
              deadline_nxt = now_r;
              settle_nxt   = 1'b0;
            end
            gas_pkg::PH_PUT_ROTATE, gas_pkg::PH_SKIP_ROTATE: begin
              if (!moving_r && !lpend_r) begin
                if (!settle_r) begin
                  settle_nxt   = 1'b1;
                  deadline_nxt = now_r + {16'd0, cfg_r[gas_pkg::CFG_GIMBAL]};
                end else if (phase_r == gas_pkg::PH_PUT_ROTATE) begin
                  ek[0] = gas_pkg::AK_SERVO; ec[0] = gas_pkg::CH_CLAW; ev[0] = -11'sd300;
                  en = 2'd1;
                  phase_nxt = gas_pkg::PH_PUT_OPEN;
                  deadline_nxt = now_r + {16'd0, cfg_r[gas_pkg::CFG_RELEASE]};
                end else begin
                  ek[0] = gas_pkg::AK_DONE;
                  en = 2'd1;
                  phase_nxt = gas_pkg::PH_IDLE;
                end
              end
            end
            gas_pkg::PH_PUT_OPEN: begin
              ek[0] = gas_pkg::AK_DONE;
              en = 2'd1;
              phase_nxt = gas_pkg::PH_IDLE;
            end
            gas_pkg::PH_BAD_DIST: begin
              ek[0] = gas_pkg::AK_SERVO; ec[0] = gas_pkg::CH_EXT; ev[0] = ext_tgt;
              ek[1] = gas_pkg::AK_SERVO; ec[1] = gas_pkg::CH_CLAW; ev[1] = 11'sd30;
              en = 2'd2;
              phase_nxt = gas_pkg::PH_BAD_CLOSE;
              deadline_nxt = now_r + {16'd0, cfg_r[gas_pkg::CFG_CLOSE]};
            end
            gas_pkg::PH_BAD_CLOSE: begin
              ek[0] = gas_pkg::AK_SERVO; ec[0] = gas_pkg::CH_CLAW; ev[0] = -11'sd300;
              en = 2'd1;
              phase_nxt = gas_pkg::PH_BAD_OPEN;
              deadline_nxt = now_r + gas_pkg::BAD_WAIT_MS;
            end
            default: ;
          endcase
        end
      end

      S_VISION: begin
        state_nxt = S_OUT;
        if (busy) begin
          if (cmd_r == gas_pkg::CMD_GRAB || cmd_r == gas_pkg::CMD_SKIP ||
              cmd_r == gas_pkg::CMD_BAD) begin
            qcmd_nxt   = cmd_r;
            qvalid_nxt = 1'b1;
          end
        end else begin
          case (cmd_r)
            gas_pkg::CMD_GIM_DN, gas_pkg::CMD_GIM_UP: begin
              if ((cmd_r == gas_pkg::CMD_GIM_DN && gim_r <= -11'sd900) ||
                  (cmd_r == gas_pkg::CMD_GIM_UP && gim_r >= 11'sd900)) begin
                if (retry_r != 8'd255) retry_nxt = retry_r + 8'd1;
                if (retry_nxt >= RETRY_LIMIT) begin
                  if (!tree_r) begin
                    ek[0] = gas_pkg::AK_SERVO; ec[0] = gas_pkg::CH_EXT; ev[0] = -11'sd800;
                    phase_nxt = gas_pkg::PH_SKIP_EXTEND;
                    deadline_nxt = now_r + {16'd0, cfg_r[gas_pkg::CFG_RETRACT]};
                  end else begin
                    ek[0] = gas_pkg::AK_DONE;
                  end
                end else begin
                  ek[0] = gas_pkg::AK_FORWARD; ev[0] = 11'sd100;
                end
                en = 2'd1;
              end else begin
                sg_go     = 1'b1;
                sg_target = {gim_r[10], gim_r} +
                            ((cmd_r == gas_pkg::CMD_GIM_DN) ? -12'sd10 : 12'sd10);
                sg_dur    = gas_pkg::STEP_MOVE_MS;
              end
            end
            gas_pkg::CMD_LIFT_UP: begin
              ek[0] = gas_pkg::AK_LIFT_UP; ev[0] = 11'sd10; en = 2'd1;
            end
            gas_pkg::CMD_LIFT_DN: begin
              ek[0] = gas_pkg::AK_LIFT_DN; ev[0] = 11'sd10; en = 2'd1;
            end
            gas_pkg::CMD_GRAB, gas_pkg::CMD_BAD: begin
              if (cmd_r == gas_pkg::CMD_GRAB) retry_nxt = 8'd0;
              en = 2'd1;
              if (tree_r) begin
                ek[0] = gas_pkg::AK_DONE;
              end else begin
                ek[0] = gas_pkg::AK_RANGE;
                if (cmd_r == gas_pkg::CMD_GRAB) begin
                  phase_nxt = gas_pkg::PH_GRAB_DIST;
                  deadline_nxt = now_r + {16'd0, cfg_r[gas_pkg::CFG_RANGE]};
                end else begin
                  phase_nxt = gas_pkg::PH_BAD_DIST;
                  deadline_nxt = now_r + gas_pkg::BAD_WAIT_MS;
                end
              end
            end
            gas_pkg::CMD_SKIP: begin
              retry_nxt = 8'd0;
              en = 2'd1;
              if (!tree_r) begin
                ek[0] = gas_pkg::AK_SERVO; ec[0] = gas_pkg::CH_EXT; ev[0] = -11'sd800;
                phase_nxt = gas_pkg::PH_SKIP_EXTEND;
                deadline_nxt = now_r + {16'd0, cfg_r[gas_pkg::CFG_RETRACT]};
              end else begin
                ek[0] = gas_pkg::AK_DONE;
              end
            end
            default: ;
          endcase
        end
      end

      S_OUT: begin
        if (rcnt_r == 3'd0) begin
          state_nxt = S_IDLE;
        end else if (out_acc) begin
          if ({1'b0, oidx_r} == rcnt_r - 3'd1) state_nxt = S_IDLE;
          else oidx_nxt = oidx_r + 2'd1;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // gimbal move start; never shares a cycle with another emission
    if (sg_go) begin
      mend_nxt = sg_end;
      mlen_nxt = sg_dur;
      if (sg_lift && (lift_r < 9'd99 || lift_r > 9'd101)) begin
        ek[0] = gas_pkg::AK_LIFT_TO; ec[0] = gas_pkg::CH_NONE; ev[0] = 11'sd250;
        en = 2'd1;
        ldead_nxt  = now_r + {16'd0, cfg_r[gas_pkg::CFG_LIFT]};
        lpend_nxt  = 1'b1;
        moving_nxt = 1'b0;
      end else begin
        mstart_nxt = gim_r;
        mtime_nxt  = now_r;
        lpend_nxt  = 1'b0;
        if (sg_dur == 16'd0 || gim_r == sg_end) begin
          ek[0] = gas_pkg::AK_SERVO; ec[0] = gas_pkg::CH_GIMBAL; ev[0] = sg_end;
          en = 2'd1;
          moving_nxt = 1'b0;
        end else begin
          moving_nxt = 1'b1;
        end
      end
    end

    rcnt_nxt = (state_r == S_IDLE) ? rcnt_nxt : rcnt_r + {1'b0, en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= gas_pkg::PH_IDLE;
      deadline_r <= '0;
      settle_r  <= 1'b0;
      retry_r   <= '0;
      moving_r  <= 1'b0;
      lpend_r   <= 1'b0;
      mstart_r  <= '0;
      mend_r    <= '0;
      mtime_r   <= '0;
      mlen_r    <= '0;
      ldead_r   <= '0;
      qvalid_r  <= 1'b0;
      qcmd_r    <= '0;
      rcnt_r    <= '0;
      oidx_r    <= '0;
      for (int i = 0; i < 8; i++) cfg_r[i] <= gas_pkg::CFG_RESET[i];
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      deadline_r <= deadline_nxt;
      settle_r   <= settle_nxt;
      retry_r    <= retry_nxt;
      moving_r   <= moving_nxt;
      lpend_r    <= lpend_nxt;
      mstart_r   <= mstart_nxt;
      mend_r     <= mend_nxt;
      mtime_r    <= mtime_nxt;
      mlen_r     <= mlen_nxt;
      ldead_r    <= ldead_nxt;
      qvalid_r   <= qvalid_nxt;
      qcmd_r     <= qcmd_nxt;
      rcnt_r     <= rcnt_nxt;
      oidx_r     <= oidx_nxt;
      if (cfg_we) cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    if (in_acc) begin
      func_r  <= in_func;
      now_r   <= in_now_ms;
      range_r <= in_range_mm;
      gim_r   <= in_gimbal_angle;
      ext_r   <= in_extend_angle;
      lift_r  <= in_lift_height;
      tree_r  <= in_tree_target;
      mtgt_r  <= in_move_target;
      mdur_r  <= in_move_duration;
    end
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < en && state_r != S_IDLE) begin
        rkind_r[2'(rcnt_r + 3'(i))] <= ek[i];
        rch_r[2'(rcnt_r + 3'(i))]   <= ec[i];
        rval_r[2'(rcnt_r + 3'(i))]  <= ev[i];
      end
    end
  end

  assign out_action_kind   = rkind_r[oidx_r];
  assign out_servo_channel = rch_r[oidx_r];
  assign out_action_value  = rval_r[oidx_r];
  assign out_last_action   = ({1'b0, oidx_r} == rcnt_r - 3'd1);
  assign out_busy_res      = busy;

endmodule

// ===== tb/grab_action_sequencer_top_tb.sv =====
`timescale 1ns / 100ps

module grab_action_sequencer_top_tb;
  import gas_pkg::*;

  typedef struct {
    logic [1:0]         func;
    logic [2:0]         cmd;
    logic [31:0]        now;
    logic [11:0]        rng;
    logic signed [10:0] gim;
    logic signed [10:0] ext;
    logic [8:0]         lift;
    logic               tree;
    logic signed [10:0] mtgt;
    logic [15:0]        mdur;
  } arm_item_t;

  typedef struct {
    logic [2:0]         kind;
    logic [2:0]         ch;
    logic signed [10:0] val;
    logic               last;
    logic               busy;
  } arm_action_t;

  // predicts the arm commands for each transaction and checks them in order
  class arm_scoreboard;
    bit [15:0]   cfg_ms[8];
    bit [3:0]    phase;
    bit [31:0]   deadline, move_t0, lift_due;
    bit          settle_armed, gim_moving, lift_wait, q_valid;
    bit [2:0]    q_cmd;
    int unsigned retries, mv_len;
    int          mv_from, mv_to;
    bit [31:0]   t_now;
    int          rng, gim, ext;
    int unsigned lift;
    bit          tree;
    arm_action_t acts[$];
    arm_action_t pending[$];
    int          errors, n_in, n_out;

    function new();
      foreach (cfg_ms[i]) cfg_ms[i] = CFG_RESET[i];
      phase = PH_IDLE;
    endfunction

    function void report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function int sat(int v);
      return v > 900 ? 900 : (v < -900 ? -900 : v);
    endfunction

    function bit due(bit [31:0] t);
      bit [31:0] d;
      d = t_now - t;
      return d[31] == 1'b0;
    endfunction

    function void emit(logic [2:0] k, logic [2:0] c, int v);
      arm_action_t a;
      a.kind = k; a.ch = c; a.val = v[10:0]; a.last = 0; a.busy = 0;
      if (acts.size() < 4) acts.push_back(a);
    endfunction

    function void servo(logic [2:0] c, int ang);
      emit(AK_SERVO, c, sat(ang));
    endfunction

    function bit busy();
      return phase != PH_IDLE || gim_moving || lift_wait;
    endfunction

    function int unsigned centre_ms(int diff);
      int unsigned m, d;
      m = diff < 0 ? -diff : diff;
      d = m * 13 / 10;
      return d < 300 ? 300 : d;
    endfunction

    function void start_gimbal(int target, int unsigned dur, bit lift_first);
      mv_to = sat(target);
      mv_len = dur & 16'hFFFF;
      if (lift_first && (lift < 99 || lift > 101)) begin
        emit(AK_LIFT_TO, CH_NONE, 250);
        lift_due = t_now + cfg_ms[CFG_LIFT];
        lift_wait = 1;
        gim_moving = 0;
        return;
      end
      mv_from = gim;
      move_t0 = t_now;
      lift_wait = 0;
      if (mv_len == 0 || mv_from == mv_to) begin
        servo(CH_GIMBAL, mv_to);
        gim_moving = 0;
      end else begin
        gim_moving = 1;
      end
    endfunction

    function void gimbal_advance();
      bit [31:0] el;
      int unsigned q;
      int d;
      if (lift_wait) begin
        if (!due(lift_due)) return;
        lift_wait = 0;
        mv_from = gim;
        move_t0 = t_now;
        gim_moving = 1;
      end
      if (!gim_moving) return;
      el = t_now - move_t0;
      if (el >= mv_len) begin
        servo(CH_GIMBAL, mv_to);
        gim_moving = 0;
        return;
      end
      d = mv_to - mv_from;
      q = (d < 0 ? -d : d) * el / mv_len;
      servo(CH_GIMBAL, d < 0 ? mv_from - int'(q) : mv_from + int'(q));
    endfunction

    function int extend_target();
      int b, t, v;
      b = ext < -800 ? -800 : ext;
      t = 2 * b + 7 * (rng + 50);
      v = (t + 1 + 4096) / 2 - 2048;
      return v > 250 ? 250 : (v < -800 ? -800 : v);
    endfunction

    function void retract_then(bit [3:0] nxt);
      servo(CH_EXT, -800);
      phase = nxt;
      deadline = t_now + cfg_ms[CFG_RETRACT];
    endfunction

    function void vision(bit [2:0] c);
      if (busy()) begin
        if (c == CMD_GRAB || c == CMD_SKIP || c == CMD_BAD) begin
          q_cmd = c;
          q_valid = 1;
        end
        return;
      end
      case (c)
        CMD_GIM_DN, CMD_GIM_UP: begin
          if ((c == CMD_GIM_DN && gim <= -900) || (c == CMD_GIM_UP && gim >= 900)) begin
            if (retries < 255) retries++;
            if (retries >= 5) begin
              if (!tree) retract_then(PH_SKIP_EXTEND);
              else emit(AK_DONE, CH_NONE, 0);
            end else begin
              emit(AK_FORWARD, CH_NONE, 100);
            end
          end else begin
            start_gimbal(gim + (c == CMD_GIM_DN ? -10 : 10), 300, 0);
          end
        end
        CMD_LIFT_UP: emit(AK_LIFT_UP, CH_NONE, 10);
        CMD_LIFT_DN: emit(AK_LIFT_DN, CH_NONE, 10);
        CMD_GRAB: begin
          retries = 0;
          if (tree) emit(AK_DONE, CH_NONE, 0);
          else begin
            emit(AK_RANGE, CH_NONE, 0);
            phase = PH_GRAB_DIST;
            deadline = t_now + cfg_ms[CFG_RANGE];
          end
        end
        CMD_SKIP: begin
          retries = 0;
          if (!tree) retract_then(PH_SKIP_EXTEND);
          else emit(AK_DONE, CH_NONE, 0);
        end
        CMD_BAD: begin
          if (tree) emit(AK_DONE, CH_NONE, 0);
          else begin
            emit(AK_RANGE, CH_NONE, 0);
            phase = PH_BAD_DIST;
            deadline = t_now + BAD_WAIT_MS;
          end
        end
        default: ;
      endcase
    endfunction

    // settle wait is armed on the first expired tick once the gimbal is still
    function void rotate_wait(bit put);
      if (gim_moving || lift_wait) return;
      if (!settle_armed) begin
        settle_armed = 1;
        deadline = t_now + cfg_ms[CFG_GIMBAL];
        return;
      end
      if (put) begin
        servo(CH_CLAW, -300);
        phase = PH_PUT_OPEN;
        deadline = t_now + cfg_ms[CFG_RELEASE];
      end else begin
        phase = PH_IDLE;
        emit(AK_DONE, CH_NONE, 0);
      end
    endfunction

    function void tick();
      int target;
      gimbal_advance();
      if (q_valid && !busy()) begin
        q_valid = 0;
        vision(q_cmd);
        return;
      end
      if (!due(deadline)) return;
      case (phase)
        PH_GRAB_DIST: begin
          servo(CH_CLAW, -300); phase = PH_GRAB_OPEN;
          deadline = t_now + cfg_ms[CFG_OPEN];
        end
        PH_GRAB_OPEN: begin
          servo(CH_EXT, extend_target()); phase = PH_GRAB_CLOSE;
          deadline = t_now + cfg_ms[CFG_EXTEND];
        end
        PH_GRAB_CLOSE: begin
          servo(CH_CLAW, 30); phase = PH_GRAB_GRIP;
          deadline = t_now + cfg_ms[CFG_CLOSE];
        end
        PH_GRAB_GRIP, PH_BAD_OPEN: retract_then(PH_PUT_EXTEND);
        PH_PUT_EXTEND: begin
          emit(AK_LIFT_TO, CH_NONE, 250); phase = PH_PUT_LIFT;
          deadline = t_now + cfg_ms[CFG_LIFT];
        end
        PH_SKIP_EXTEND: begin
          emit(AK_LIFT_TO, CH_NONE, 250); phase = PH_SKIP_LIFT;
          deadline = t_now + cfg_ms[CFG_LIFT];
        end
        PH_PUT_LIFT: begin
          start_gimbal(0, centre_ms(gim), 0);
          phase = PH_PUT_ROTATE; deadline = t_now; settle_armed = 0;
        end
        PH_SKIP_LIFT: begin
          target = gim > 750 ? -900 : 0;
          start_gimbal(target, centre_ms(target - gim), 0);
          phase = PH_SKIP_ROTATE; deadline = t_now; settle_armed = 0;
        end
        PH_PUT_ROTATE: rotate_wait(1);
        PH_SKIP_ROTATE: rotate_wait(0);
        PH_PUT_OPEN: begin
          phase = PH_IDLE; emit(AK_DONE, CH_NONE, 0);
        end
        PH_BAD_DIST: begin
          servo(CH_EXT, extend_target()); servo(CH_CLAW, 30);
          phase = PH_BAD_CLOSE; deadline = t_now + cfg_ms[CFG_CLOSE];
        end
        PH_BAD_CLOSE: begin
          servo(CH_CLAW, -300); phase = PH_BAD_OPEN;
          deadline = t_now + BAD_WAIT_MS;
        end
        default: ;
      endcase
    endfunction

    function void note_input(arm_item_t it);
      bit b;
      acts.delete();
      t_now = it.now; rng = it.rng; gim = it.gim; ext = it.ext;
      lift = it.lift; tree = it.tree;
      case (it.func)
        FN_TICK:   tick();
        FN_VISION: vision(it.cmd);
        FN_CANCEL: begin
          phase = PH_IDLE; gim_moving = 0; lift_wait = 0; q_valid = 0;
        end
        default:   start_gimbal(it.mtgt, it.mdur, 1);
      endcase
      b = busy();
      foreach (acts[i]) begin
        acts[i].last = (i == acts.size() - 1);
        acts[i].busy = b;
        pending.push_back(acts[i]);
      end
      n_in++;
    endfunction

    function void check_result(arm_action_t got);
      arm_action_t e;
      n_out++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result kind=%0d ch=%0d val=%0d",
                         got.kind, got.ch, got.val));
        return;
      end
      e = pending.pop_front();
      if (got.kind !== e.kind)
        report($sformatf("action_kind %0d, expected %0d", got.kind, e.kind));
      if (got.ch !== e.ch)
        report($sformatf("servo_channel %0d, expected %0d", got.ch, e.ch));
      if (got.val !== e.val)
        report($sformatf("action_value %0d, expected %0d", got.val, e.val));
      if (got.last !== e.last)
        report($sformatf("last_action %0b, expected %0b", got.last, e.last));
      if (got.busy !== e.busy)
        report($sformatf("busy_res %0b, expected %0b", got.busy, e.busy));
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         in_func = FN_TICK;
  logic [2:0]         in_vision_command = CMD_GRAB;
  logic [31:0]        in_now_ms = 0;
  logic [11:0]        in_range_mm = 0;
  logic signed [10:0] in_gimbal_angle = 0;
  logic signed [10:0] in_extend_angle = 0;
  logic [8:0]         in_lift_height = 0;
  logic               in_tree_target = 0;
  logic signed [10:0] in_move_target = 0;
  logic [15:0]        in_move_duration = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [2:0]         out_action_kind;
  logic [2:0]         out_servo_channel;
  logic signed [10:0] out_action_value;
  logic               out_last_action;
  logic               out_busy_res;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = CFG_RANGE;
  logic [15:0]        cfg_wdata = 0;

  arm_scoreboard sb = new();
  bit          no_idle;
  int          rx_wait;
  bit [31:0]   clock_ms = 32'd1000;
  int          n_settings;

  grab_action_sequencer_top i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    arm_action_t a;
    if (rst_n && out_valid && !out_stall) begin
      a.kind = out_action_kind; a.ch = out_servo_channel; a.val = out_action_value;
      a.last = out_last_action; a.busy = out_busy_res;
      sb.check_result(a);
      rx_wait = no_idle ? 0 : $urandom_range(0, 10);
    end
  end

  always @(negedge clk) begin
    out_stall <= (rx_wait > 0);
    if (rx_wait > 0) rx_wait--;
  end

  function automatic arm_item_t rand_item(logic [1:0] f, logic [2:0] c);
    arm_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) clock_ms += $urandom_range(0, 70000);
    else if (r < 4) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 60);
    it.func = f;
    it.cmd  = c;
    it.now  = clock_ms;
    it.rng  = $urandom_range(0, 4095);
    r = $urandom_range(0, 9);
    it.gim  = r == 0 ? -900 : (r == 1 ? 900 : $urandom_range(0, 1800) - 900);
    it.ext  = $urandom_range(0, 1800) - 900;
    it.lift = $urandom_range(0, 4) == 0 ? $urandom_range(99, 101) : $urandom_range(0, 400);
    it.tree = $urandom_range(0, 4) == 0;
    it.mtgt = $urandom_range(0, 1800) - 900;
    r = $urandom_range(0, 19);
    it.mdur = r == 0 ? 0 : (r < 3 ? $urandom_range(0, 65535) : $urandom_range(1, 600));
    return it;
  endfunction

  function automatic arm_item_t random_transaction();
    int r;
    logic [2:0] c;
    r = $urandom_range(0, 99);
    if (r < 55) return rand_item(FN_TICK, CMD_GRAB);
    if (r < 87) begin
      r = $urandom_range(0, 9);
      c = r < 3 ? CMD_GRAB : (r < 5 ? CMD_SKIP : (r < 7 ? CMD_BAD : $urandom_range(1, 7)));
      return rand_item(FN_VISION, c);
    end
    if (r < 97) return rand_item(FN_MOVE, CMD_GRAB);
    return rand_item(FN_CANCEL, CMD_GRAB);
  endfunction

  // starts and ends at a falling edge
  task automatic send(arm_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_func <= it.func; in_vision_command <= it.cmd; in_now_ms <= it.now;
    in_range_mm <= it.rng; in_gimbal_angle <= it.gim; in_extend_angle <= it.ext;
    in_lift_height <= it.lift; in_tree_target <= it.tree;
    in_move_target <= it.mtgt; in_move_duration <= it.mdur;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_cfg(bit [15:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1; cfg_index <= i[2:0]; cfg_wdata <= v[i];
      sb.cfg_ms[i] = v[i];
      @(negedge clk);
    end
    cfg_we <= 0;
    @(negedge clk);
    n_settings++;
  endtask

  initial begin
    arm_item_t it;
    bit [15:0] v[8];
    rx_wait = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: lift, gimbal and unknown commands at idle, retry give-up, queueing, moves, wrap
    it = rand_item(FN_TICK, CMD_GRAB); send(it);
    it = rand_item(FN_VISION, CMD_LIFT_UP); send(it);
    it = rand_item(FN_VISION, CMD_LIFT_DN); send(it);
    it = rand_item(FN_VISION, 3'd7); send(it);
    it = rand_item(FN_VISION, CMD_GIM_DN); it.gim = 0; send(it);
    clock_ms += 400;
    it = rand_item(FN_TICK, CMD_GRAB); it.now = clock_ms; send(it);
    for (int i = 0; i < 6; i++) begin
      it = rand_item(FN_VISION, CMD_GIM_UP); it.gim = 900; it.tree = 1; send(it);
    end
    it = rand_item(FN_VISION, CMD_GIM_DN); it.gim = -900; it.tree = 0; send(it);
    it = rand_item(FN_VISION, CMD_GRAB); it.tree = 1; send(it);
    it = rand_item(FN_VISION, CMD_SKIP); it.tree = 1; send(it);
    it = rand_item(FN_VISION, CMD_BAD); it.tree = 1; send(it);
    it = rand_item(FN_VISION, CMD_GRAB); it.tree = 0; send(it);
    it = rand_item(FN_VISION, CMD_BAD); send(it);
    it = rand_item(FN_CANCEL, CMD_GRAB); send(it);
    it = rand_item(FN_MOVE, CMD_GRAB); it.lift = 0; it.mtgt = 900; send(it);
    it = rand_item(FN_MOVE, CMD_GRAB); it.lift = 100; it.mtgt = -900; it.mdur = 0;
    send(it);
    it = rand_item(FN_MOVE, CMD_GRAB); it.lift = 400; it.mdur = 65535; send(it);
    clock_ms = 32'hFFFF_FFF0;
    it = rand_item(FN_VISION, CMD_SKIP); it.tree = 0; it.rng = 4095;
    it.ext = -900; send(it);
    it = rand_item(FN_TICK, CMD_GRAB); send(it);
    it = rand_item(FN_CANCEL, CMD_GRAB); send(it);
    drain();

    for (int p = 0; p < 4; p++) begin
      foreach (v[i]) begin
        case (p)
          0: v[i] = CFG_RESET[i];
          1: v[i] = $urandom_range(0, 100);
          2: v[i] = (i % 2) ? 16'hFFFF : 16'h0000;
          default: v[i] = (i % 2) ? 16'h0000 : $urandom_range(0, 400);
        endcase
      end
      write_cfg(v);
      no_idle = (p == 1);
      for (int n = 0; n < 88; n++) send(random_transaction());
      drain();
    end

    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    $display("Covered %0d transactions in, %0d results out, %0d register settings",
             sb.n_in, sb.n_out, n_settings);
    $display("grab, skip, bad-fruit, gimbal and lift paths with random stalls");
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== grab_action_sequencer_top.f =====
rtl/gas_pkg.sv
rtl/gas_div.sv
rtl/grab_action_sequencer_top.sv
tb/grab_action_sequencer_top_tb.sv
